/* hdl/bctt_pkg.sv */
package bctt_pkg;

    // Field and register widths
    localparam int PRICE_W    = 32;
    localparam int TGT_LO_W   = 64;
    localparam int TGT_HI_W   = 31;
    localparam int RAT_W      = 31;
    localparam int AMT_W      = 63;
    localparam int VAL_W      = 96;
    localparam int SUM_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int STATUS_W   = 2;

    // Radix-4 divider: two quotient bits per step over a 96-bit dividend
    localparam int DIV_STEPS  = VAL_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PRICE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELL_PRICE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUY_PRICE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 2'd3;

    localparam logic [AMT_W-1:0] AMT_MAX = '1;

    typedef struct packed {
        logic             req_type;
        logic [RAT_W-1:0] price_num;
        logic [RAT_W-1:0] price_den;
        logic [AMT_W-1:0] offer_amount;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AMT_W-1:0]    sold_amount;
        logic [AMT_W-1:0]    bought_amount;
        logic                done_res;
    } res_t;

endpackage

/* hdl/bctt_if.sv */
interface bctt_req_if;
    logic             valid;
    logic             ready;
    bctt_pkg::req_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bctt_res_if;
    logic             valid;
    logic             ready;
    bctt_pkg::res_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bctt_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bctt_pkg::CFG_IDX_W-1:0]      index;
    logic [bctt_pkg::CFG_DATA_W-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* hdl/batch_clearing_target_tracker.sv */
// A clear request runs the price test, forms the offered value, takes the smaller of it and
// the remaining target and then divides; a finish request skips the price test and the offer;
// a clear request with a rejected price goes straight to the result. One request is taken at a
// time, and a finished result waits while the receiver holds off an earlier one; the sequence
// ends with two 48-step radix-4 divisions of the cleared value by the sell and buy prices.
// Reset (rst_n, asynchronous, active low) sets both prices to 1, the target and the realized
// total to zero, empties the result register and leaves the block ready at once.
module batch_clearing_target_tracker (
    input  logic        clk,
    input  logic        rst_n,
    bctt_cfg_if.sink    cfg,
    bctt_req_if.sink    req,
    bctt_res_if.source  res
);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_REM    = 4'd1;
    localparam logic [3:0] S_PR1    = 4'd2;
    localparam logic [3:0] S_PR2    = 4'd3;
    localparam logic [3:0] S_OF1    = 4'd4;
    localparam logic [3:0] S_OF2    = 4'd5;
    localparam logic [3:0] S_MIN    = 4'd6;
    localparam logic [3:0] S_UPD    = 4'd7;
    localparam logic [3:0] S_DV1    = 4'd8;
    localparam logic [3:0] S_SOLD   = 4'd9;
    localparam logic [3:0] S_DV2    = 4'd10;
    localparam logic [3:0] S_BOUGHT = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic [bctt_pkg::DIV_CNT_W-1:0] DIV_CNT_LAST =
        bctt_pkg::DIV_CNT_W'(bctt_pkg::DIV_STEPS - 1);

    // Configuration registers
    logic [bctt_pkg::PRICE_W-1:0]  sell_price_reg;
    logic [bctt_pkg::PRICE_W-1:0]  buy_price_reg;
    logic [bctt_pkg::TGT_LO_W-1:0] target_low_reg;
    logic [bctt_pkg::TGT_HI_W-1:0] target_high_reg;

    // Tracker state
    logic [bctt_pkg::VAL_W-1:0]    realized_reg;
    logic [bctt_pkg::SUM_W-1:0]    total_sold_reg;
    logic [bctt_pkg::SUM_W-1:0]    total_bought_reg;

    // Sequencer and working registers
    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;
    bctt_pkg::req_t                item_reg;
    logic [63:0]                   prod_reg;
    logic [bctt_pkg::VAL_W-1:0]    acc_reg;
    logic [bctt_pkg::VAL_W-1:0]    remain_reg;
    logic [bctt_pkg::VAL_W-1:0]    cur_reg;
    logic [bctt_pkg::VAL_W-1:0]    dq_reg;
    logic [bctt_pkg::PRICE_W-1:0]  rem_reg;
    logic [bctt_pkg::PRICE_W+1:0]  d3_reg;
    logic [bctt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [bctt_pkg::AMT_W-1:0]    sold_reg;
    logic [bctt_pkg::AMT_W-1:0]    bought_reg;
    logic                          ovf_reg;
    logic                          bad_reg;

    // Result register
    logic                          res_valid_reg;
    bctt_pkg::res_t                res_data_reg;

    // Combinational signals
    logic [bctt_pkg::PRICE_W-1:0]  sp_eff;
    logic [bctt_pkg::PRICE_W-1:0]  bp_eff;
    logic [bctt_pkg::VAL_W-1:0]    target_val;
    logic [bctt_pkg::VAL_W:0]      diff;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic [bctt_pkg::PRICE_W-1:0]  d_sel;
    logic [bctt_pkg::PRICE_W+1:0]  d1;
    logic [bctt_pkg::PRICE_W+1:0]  d2;
    logic [bctt_pkg::PRICE_W+1:0]  div_x;
    logic [bctt_pkg::PRICE_W+1:0]  div_sub;
    logic [1:0]                    div_digit;
    logic [bctt_pkg::PRICE_W+1:0]  div_rem;
    logic [bctt_pkg::VAL_W-1:0]    qsum;
    logic                          in_xfer;
    logic                          res_load;

    // A price register holding zero behaves as a price of one.
    assign sp_eff = (sell_price_reg == '0) ? bctt_pkg::PRICE_W'(1) : sell_price_reg;
    assign bp_eff = (buy_price_reg == '0) ? bctt_pkg::PRICE_W'(1) : buy_price_reg;

    assign target_val = {1'b0, target_high_reg, target_low_reg};

    // The remaining target is zero whenever the realized total has reached or passed it,
    // which the borrow of a single wide subtraction tells.
    assign diff = {1'b0, target_val} - {1'b0, realized_reg};

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign in_xfer   = req.valid && req.ready;

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // The result register is loaded once the slot is free or is being emptied in the
    // same cycle, so a finished result waits only while an earlier one is still held off.
    assign res_load = (state_reg == S_OUT) && (!res_valid_reg || res.ready);

    // Configuration writes. The user must write them only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sell_price_reg  <= bctt_pkg::PRICE_W'(1);
            buy_price_reg   <= bctt_pkg::PRICE_W'(1);
            target_low_reg  <= '0;
            target_high_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                bctt_pkg::REG_SELL_PRICE:  sell_price_reg  <= cfg.wdata[bctt_pkg::PRICE_W-1:0];
                bctt_pkg::REG_BUY_PRICE:   buy_price_reg   <= cfg.wdata[bctt_pkg::PRICE_W-1:0];
                bctt_pkg::REG_TARGET_LOW:  target_low_reg  <= cfg.wdata;
                bctt_pkg::REG_TARGET_HIGH: target_high_reg <= cfg.wdata[bctt_pkg::TGT_HI_W-1:0];
                default:                   ;
            endcase
        end
    end

    // The one shared 32 by 32 multiplier. It first forms the two sides of the price test,
    // then the low and high partial products of the offered value.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_REM:
            begin
                mul_a = {1'b0, item_reg.price_num};
                mul_b = bp_eff;
            end
            S_PR1:
            begin
                mul_a = {1'b0, item_reg.price_den};
                mul_b = sp_eff;
            end
            S_PR2:
            begin
                mul_a = item_reg.offer_amount[31:0];
                mul_b = sp_eff;
            end
            S_OF1:
            begin
                mul_a = {1'b0, item_reg.offer_amount[62:32]};
                mul_b = sp_eff;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One radix-4 divider step: the partial remainder takes the next two dividend bits and
    // is tested against one, two and three times the divisor. Three times the divisor is
    // held in a register, set before each division starts.
    assign d_sel = (state_reg == S_DV2) ? bp_eff : sp_eff;
    assign d1    = {2'b00, d_sel};
    assign d2    = {1'b0, d_sel, 1'b0};
    assign div_x = {rem_reg, dq_reg[bctt_pkg::VAL_W-1 -: 2]};

    always_comb
    begin
        if (div_x >= d3_reg)
        begin
            div_digit = 2'd3;
            div_sub   = d3_reg;
        end
        else if (div_x >= d2)
        begin
            div_digit = 2'd2;
            div_sub   = d2;
        end
        else if (div_x >= d1)
        begin
            div_digit = 2'd1;
            div_sub   = d1;
        end
        else
        begin
            div_digit = 2'd0;
            div_sub   = '0;
        end
    end

    assign div_rem = div_x - div_sub;

    // The sold amount rounds up: one is added when the division leaves a remainder.
    assign qsum = dq_reg + bctt_pkg::VAL_W'(rem_reg != '0);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_xfer) state_next = S_REM;
            S_REM:    state_next = item_reg.req_type ? S_MIN : S_PR1;
            S_PR1:    state_next = S_PR2;
            S_PR2:    state_next = (acc_reg[63:0] > prod_reg) ? S_OUT : S_OF1;
            S_OF1:    state_next = S_OF2;
            S_OF2:    state_next = S_MIN;
            S_MIN:    state_next = S_UPD;
            S_UPD:    state_next = S_DV1;
            S_DV1:    if (cnt_reg == DIV_CNT_LAST) state_next = S_SOLD;
            S_SOLD:   state_next = S_DV2;
            S_DV2:    if (cnt_reg == DIV_CNT_LAST) state_next = S_BOUGHT;
            S_BOUGHT: state_next = S_OUT;
            S_OUT:    if (res_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of the datapath. They need no reset: each request loads them
    // before they are read.
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);

        if (in_xfer)
        begin
            item_reg <= req.data;
            ovf_reg  <= 1'b0;
            bad_reg  <= 1'b0;
        end

        case (state_reg)
            S_REM:
            begin
                remain_reg <= diff[bctt_pkg::VAL_W] ? '0 : diff[bctt_pkg::VAL_W-1:0];
            end
            S_PR1:
            begin
                acc_reg <= {32'b0, prod_reg};
            end
            S_PR2:
            begin
                if (acc_reg[63:0] > prod_reg)
                begin
                    bad_reg    <= 1'b1;
                    sold_reg   <= '0;
                    bought_reg <= '0;
                end
            end
            S_OF1:
            begin
                acc_reg <= {32'b0, prod_reg};
            end
            S_OF2:
            begin
                acc_reg <= acc_reg + {prod_reg, 32'b0};
            end
            S_MIN:
            begin
                cur_reg <= (item_reg.req_type || remain_reg <= acc_reg) ? remain_reg : acc_reg;
            end
            S_UPD:
            begin
                dq_reg  <= cur_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
                d3_reg  <= {2'b00, sp_eff} + {1'b0, sp_eff, 1'b0};
            end
            S_DV1, S_DV2:
            begin
                dq_reg  <= {dq_reg[bctt_pkg::VAL_W-3:0], div_digit};
                rem_reg <= div_rem[bctt_pkg::PRICE_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_SOLD:
            begin
                if (qsum[bctt_pkg::VAL_W-1:bctt_pkg::AMT_W] != '0)
                begin
                    sold_reg <= bctt_pkg::AMT_MAX;
                    ovf_reg  <= 1'b1;
                end
                else
                begin
                    sold_reg <= qsum[bctt_pkg::AMT_W-1:0];
                end
                dq_reg  <= cur_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
                d3_reg  <= {2'b00, bp_eff} + {1'b0, bp_eff, 1'b0};
            end
            S_BOUGHT:
            begin
                if (dq_reg[bctt_pkg::VAL_W-1:bctt_pkg::AMT_W] != '0)
                begin
                    bought_reg <= bctt_pkg::AMT_MAX;
                    ovf_reg    <= 1'b1;
                end
                else
                begin
                    bought_reg <= dq_reg[bctt_pkg::AMT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // The realized total grows by the cleared value once per request that is not rejected; the running
    // sums of reported amounts wrap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            realized_reg     <= '0;
            total_sold_reg   <= '0;
            total_bought_reg <= '0;
        end
        else
        begin
            if (state_reg == S_UPD)
            begin
                realized_reg <= realized_reg + cur_reg;
            end
            if (res_load && !bad_reg)
            begin
                total_sold_reg   <= total_sold_reg + {1'b0, sold_reg};
                total_bought_reg <= total_bought_reg + {1'b0, bought_reg};
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (bad_reg)
            begin
                res_data_reg.status <= bctt_pkg::ST_BAD_PRICE;
            end
            else if (ovf_reg)
            begin
                res_data_reg.status <= bctt_pkg::ST_OVERFLOW;
            end
            else
            begin
                res_data_reg.status <= bctt_pkg::ST_OK;
            end
            res_data_reg.sold_amount   <= sold_reg;
            res_data_reg.bought_amount <= bought_reg;
            res_data_reg.done_res      <= (realized_reg == target_val);
        end
    end

    // A transfer in closes the input until the result register has been loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("input open while a request is being worked on");

    // The divider's partial remainder stays below the divisor throughout a division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DV1 || state_reg == S_DV2) |-> (rem_reg < d_sel))
        else $error("divider partial remainder not below divisor");

    // A rejected price reports no amounts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.status == bctt_pkg::ST_BAD_PRICE)
            |-> (res.data.sold_amount == '0 && res.data.bought_amount == '0))
        else $error("rejected request reports an amount");

    // An overflow status comes with at least one saturated amount.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.status == bctt_pkg::ST_OVERFLOW)
            |-> (res.data.sold_amount == bctt_pkg::AMT_MAX
                 || res.data.bought_amount == bctt_pkg::AMT_MAX))
        else $error("overflow status without a saturated amount");

endmodule
